// File: rtl/lsfa_pkg.sv
`default_nettype none
package lsfa_pkg;

	localparam int PIXELS      = 4096;
	localparam int SAMPLE_BITS = 12;
	localparam int ADDR_W      = $clog2(PIXELS);
	localparam int SUM_W       = 20;
	localparam int IDX_W       = 12;
	localparam int SMP_W       = 12;
	localparam int KIND_W      = 2;
	localparam int CNT_W       = 8;

	localparam logic [KIND_W-1:0] KIND_SINGLE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_FIRST  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_MIDDLE = 2'd2;
	localparam logic [KIND_W-1:0] KIND_LAST   = 2'd3;

	localparam logic [SUM_W-1:0] SUM_MAX = '1;

	// One item in flight through the divider
	typedef struct packed {
		logic [IDX_W-1:0]       idx;
		logic                   pass;
		logic                   sat;
		logic [CNT_W-1:0]       rem;
		logic [SAMPLE_BITS-1:0] dq;
		logic [CNT_W-1:0]       dvs;
	} div_item_t;

endpackage
`default_nettype wire

// File: rtl/lsfa_in_if.sv
`default_nettype none
interface lsfa_in_if;
	logic                        valid;
	logic                        ready;
	logic [lsfa_pkg::KIND_W-1:0] kind;
	logic [lsfa_pkg::IDX_W-1:0]  pixel_index;
	logic [lsfa_pkg::SMP_W-1:0]  sample;

	modport source(output valid, kind, pixel_index, sample, input ready);
	modport sink(input valid, kind, pixel_index, sample, output ready);
endinterface
`default_nettype wire

// File: rtl/lsfa_out_if.sv
`default_nettype none
interface lsfa_out_if;
	logic                       valid;
	logic                       ready;
	logic [lsfa_pkg::IDX_W-1:0] out_index;
	logic [lsfa_pkg::SMP_W-1:0] out_value;

	modport source(output valid, out_index, out_value, input ready);
	modport sink(input valid, out_index, out_value, output ready);
endinterface
`default_nettype wire

// File: rtl/lsfa_accum.sv
`default_nettype none
module lsfa_accum (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	lsfa_in_if.sink                         in_ch,
	input  wire logic [lsfa_pkg::CNT_W-1:0] dvs,
	input  wire logic                       div_ready,
	output lsfa_pkg::div_item_t             div_item,
	output logic                            div_valid
);
	localparam int AW = lsfa_pkg::ADDR_W;
	localparam int SW = lsfa_pkg::SUM_W;
	localparam int SB = lsfa_pkg::SAMPLE_BITS;
	localparam int CW = lsfa_pkg::CNT_W;

	logic [SW-1:0] mem [lsfa_pkg::PIXELS];

	logic                          in_fire;
	logic                          in_ok;
	logic [AW-1:0]                 in_addr;
	logic [SB-1:0]                 in_smp;

	logic                          v_s1;
	logic [lsfa_pkg::KIND_W-1:0]   kind_s1;
	logic [lsfa_pkg::IDX_W-1:0]    idx_s1;
	logic [AW-1:0]                 addr_s1;
	logic                          ok_s1;
	logic [SB-1:0]                 smp_s1;
	logic [CW-1:0]                 dvs_s1;
	logic                          fwd_s1;
	logic [SW-1:0]                 fwd_data_s1;
	logic [SW-1:0]                 rd_s1;

	logic                          res_s1;
	logic                          s1_leave;
	logic [SW-1:0]                 old_sum;
	logic [SW:0]                   sum_wide;
	logic [SW-1:0]                 sum_sat;
	logic [SW-1:0]                 wr_data;
	logic                          mem_we;
	logic [SW-1:0]                 hi;

	assign in_fire = in_ch.valid && in_ch.ready;
	assign in_ok   = 32'(in_ch.pixel_index) < 32'(lsfa_pkg::PIXELS);
	assign in_addr = AW'(in_ch.pixel_index);
	assign in_smp  = SB'(in_ch.sample);

	assign res_s1   = (kind_s1 == lsfa_pkg::KIND_SINGLE) || (kind_s1 == lsfa_pkg::KIND_LAST);
	assign s1_leave = v_s1 && (!res_s1 || div_ready);
	assign in_ch.ready = !v_s1 || s1_leave;

	// Take the entry just written by the previous item if it is the same pixel
	assign old_sum  = !ok_s1 ? '0 : (fwd_s1 ? fwd_data_s1 : rd_s1);
	assign sum_wide = {1'b0, old_sum} + (SW+1)'(smp_s1);
	assign sum_sat  = sum_wide[SW] ? lsfa_pkg::SUM_MAX : sum_wide[SW-1:0];
	assign wr_data  = (kind_s1 == lsfa_pkg::KIND_FIRST) ? SW'(smp_s1) : sum_sat;
	assign mem_we   = s1_leave && ok_s1 && (kind_s1 != lsfa_pkg::KIND_SINGLE);

	assign hi = sum_sat >> SB;

	always_comb begin
		div_item.idx = idx_s1;
		div_item.dvs = dvs_s1;
		if (kind_s1 == lsfa_pkg::KIND_SINGLE) begin
			div_item.pass = 1'b1;
			div_item.sat  = 1'b0;
			div_item.rem  = '0;
			div_item.dq   = smp_s1;
		end else begin
			div_item.pass = 1'b0;
			// quotient needs more than SB bits: saturate
			div_item.sat  = hi >= SW'(dvs_s1);
			div_item.rem  = CW'(hi);
			div_item.dq   = sum_sat[SB-1:0];
		end
	end

	assign div_valid = v_s1 && res_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			v_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			kind_s1     <= in_ch.kind;
			idx_s1      <= in_ch.pixel_index;
			addr_s1     <= in_addr;
			ok_s1       <= in_ok;
			smp_s1      <= in_smp;
			dvs_s1      <= dvs;
			fwd_s1      <= mem_we && (addr_s1 == in_addr);
			fwd_data_s1 <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[addr_s1] <= wr_data;
		end
		if (in_fire) begin
			rd_s1 <= mem[in_addr];
		end
	end

	a_accept_frees_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && v_s1 |-> s1_leave)
		else $error("item accepted while s1 item stays");

	a_forward_hit: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && in_ok && mem_we && (addr_s1 == in_addr) |=> old_sum == $past(wr_data))
		else $error("back-to-back same pixel did not see forwarded sum");

	a_single_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && (kind_s1 == lsfa_pkg::KIND_SINGLE) |-> !mem_we)
		else $error("pass-through item wrote the accumulator");

endmodule
`default_nettype wire

// File: rtl/lsfa_div.sv
`default_nettype none
module lsfa_div (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire lsfa_pkg::div_item_t  in_item,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	lsfa_out_if.source                out_ch
);
	localparam int SB = lsfa_pkg::SAMPLE_BITS;
	localparam int CW = lsfa_pkg::CNT_W;
	localparam int NS = SB + 1;

	logic                val_s [NS];
	lsfa_pkg::div_item_t itm_s [NS];
	logic                rdy   [NS];
	logic [SB-1:0]       res;

	// One restoring-division step: one quotient bit
	function automatic lsfa_pkg::div_item_t div_step(input lsfa_pkg::div_item_t x);
		lsfa_pkg::div_item_t y;
		logic [CW:0]         rem2;
		logic                ge;
		y    = x;
		rem2 = {x.rem, x.dq[SB-1]};
		ge   = rem2 >= {1'b0, x.dvs};
		if (!x.pass && !x.sat) begin
			y.rem = ge ? CW'(rem2 - {1'b0, x.dvs}) : CW'(rem2);
			y.dq  = {x.dq[SB-2:0], ge};
		end
		return y;
	endfunction

	always_comb begin
		rdy[NS-1] = !val_s[NS-1] || out_ch.ready;
		for (int k = NS - 2; k >= 0; k--) begin
			rdy[k] = !val_s[k] || rdy[k+1];
		end
	end

	assign in_ready = rdy[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NS; k++) begin
				val_s[k] <= 1'b0;
			end
		end else begin
			if (rdy[0]) begin
				val_s[0] <= in_valid;
			end
			for (int k = 1; k < NS; k++) begin
				if (rdy[k]) begin
					val_s[k] <= val_s[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			itm_s[0] <= in_item;
		end
		for (int k = 1; k < NS; k++) begin
			if (rdy[k]) begin
				itm_s[k] <= div_step(itm_s[k-1]);
			end
		end
	end

	assign res              = itm_s[NS-1].sat ? '1 : itm_s[NS-1].dq;
	assign out_ch.valid     = val_s[NS-1];
	assign out_ch.out_index = itm_s[NS-1].idx;
	assign out_ch.out_value = lsfa_pkg::SMP_W'(res);

	a_stage0_hold: assert property (@(posedge clk) disable iff (!arst_n)
		val_s[0] && !rdy[1] |=> val_s[0] && $stable(itm_s[0]))
		else $error("stalled divider stage lost its item");

endmodule
`default_nettype wire

// File: rtl/line_sensor_frame_averager_core.sv
// Channel   Dir  Payload                               Handshake
// pix_in    in   kind, pixel_index, sample             valid & ready
// pix_out   out  out_index, out_value                  valid & ready
// cfg       in   cfg_wdata (frames_to_average)         cfg_we, no wait
//
// One item per cycle sustained while pix_out is ready; accumulator read, add
// and write back in one stage with forwarding for the same pixel on
// consecutive items. Results then pass the divider's input register and its
// one-bit-per-stage restoring steps after the accumulator stage.
// Reset clears control only; the accumulator memory is not cleared.
// Stalls on pix_out back up stage by stage; pix_in is taken while bubbles remain.
`default_nettype none
module line_sensor_frame_averager_core (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [lsfa_pkg::CNT_W-1:0] cfg_wdata,
	lsfa_in_if.sink                         pix_in,
	lsfa_out_if.source                      pix_out
);
	logic [lsfa_pkg::CNT_W-1:0] frames_q;
	logic [lsfa_pkg::CNT_W-1:0] dvs;
	lsfa_pkg::div_item_t        div_item;
	logic                       div_valid;
	logic                       div_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= lsfa_pkg::CNT_W'(1);
		end else if (cfg_we) begin
			frames_q <= cfg_wdata;
		end
	end

	// zero frames divides by one
	assign dvs = (frames_q == '0) ? lsfa_pkg::CNT_W'(1) : frames_q;

	lsfa_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (pix_in),
		.dvs       (dvs),
		.div_ready (div_ready),
		.div_item  (div_item),
		.div_valid (div_valid)
	);

	lsfa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_item  (div_item),
		.in_valid (div_valid),
		.in_ready (div_ready),
		.out_ch   (pix_out)
	);

endmodule
`default_nettype wire
